// ----- src/u8u16_pkg.sv -----
package u8u16_pkg;

  // output queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [15:0] REPL_RESET  = 16'h003F;
  localparam logic [7:0]  LEAD_E0     = 8'hE0;
  localparam logic [15:0] SUR_HI_BASE = 16'hD800;
  localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
  localparam logic [20:0] SUR_MIN     = 21'h00D800;
  localparam logic [20:0] SUR_MAX     = 21'h00DFFF;
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [20:0] UNI_MAX     = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_t;

  // up to two units produced by one input word, in order units[0], units[1]
  typedef struct packed {
    logic [1:0]      n;
    unit_t [1:0]     units;
  } dec_res_t;

endpackage

// ----- src/u8u16_if.sv -----
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ----- src/u8u16_decode.sv -----
module u8u16_decode
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  in_byte,
  input  logic        eos,
  input  logic [15:0] repl,
  output dec_res_t    res
);

  logic [1:0]  rem_r, rem_nxt, len_r, len_nxt, rem_dec;
  logic [20:0] acc_r, acc_nxt, acc_shift, supp;
  logic        bad_r, bad_nxt, e0_r, e0_nxt, nonascii_r, nonascii_nxt, bad_seq;

  always_comb begin
    rem_nxt      = rem_r;
    len_nxt      = len_r;
    acc_nxt      = acc_r;
    bad_nxt      = bad_r;
    e0_nxt       = e0_r;
    nonascii_nxt = nonascii_r;
    res          = '0;
    bad_seq      = bad_r | (in_byte[7:6] != 2'b10)
                 | (e0_r && rem_r == 2'd2 && in_byte[7:5] == 3'b100);
    acc_shift    = {acc_r[14:0], in_byte[5:0]};
    rem_dec      = rem_r - 2'd1;
    supp         = acc_shift - SUPP_BASE;

    if (rem_r == 2'd0) begin
      if (!in_byte[7]) begin
        res.n = 2'd1;
        res.units[0].code_unit = (in_byte == 8'h00 && nonascii_r) ? repl : {8'h00, in_byte};
      end else begin
        nonascii_nxt = 1'b1;
        priority if (in_byte[7:5] == 3'b110) begin
          len_nxt = 2'd1;
          acc_nxt = {16'h0000, in_byte[4:0]};
          bad_nxt = (in_byte[4:1] == 4'h0);
        end else if (in_byte[7:4] == 4'b1110) begin
          len_nxt = 2'd2;
          acc_nxt = {17'h00000, in_byte[3:0]};
          e0_nxt  = (in_byte == LEAD_E0);
        end else if (in_byte[7:3] == 5'b11110) begin
          len_nxt = 2'd3;
          acc_nxt = {18'h00000, in_byte[2:0]};
        end else begin
          // stray continuation or invalid lead
          len_nxt = 2'd0;
          res.n   = 2'd1;
          res.units[0].code_unit = repl;
        end
        rem_nxt = len_nxt;
      end
    end else if (rem_dec == 2'd0) begin
      // sequence complete
      res.n = 2'd1;
      priority if (bad_seq) begin
        res.units[0].code_unit = repl;
      end else if (len_r == 2'd1) begin
        res.units[0].code_unit = acc_shift[15:0];
      end else if (len_r == 2'd2) begin
        res.units[0].code_unit = (acc_shift >= SUR_MIN && acc_shift <= SUR_MAX)
                               ? repl : acc_shift[15:0];
      end else if (acc_shift <= BMP_MAX || acc_shift > UNI_MAX) begin
        res.units[0].code_unit = repl;
      end else begin
        res.n = 2'd2;
        res.units[0].code_unit = SUR_HI_BASE + {6'b000000, supp[19:10]};
        res.units[1].code_unit = SUR_LO_BASE + {6'b000000, supp[9:0]};
      end
      rem_nxt = 2'd0;
      len_nxt = 2'd0;
      acc_nxt = '0;
      bad_nxt = 1'b0;
      e0_nxt  = 1'b0;
    end else begin
      rem_nxt = rem_dec;
      acc_nxt = acc_shift;
      bad_nxt = bad_seq;
    end

    if (eos) begin
      // cut short sequence gets one replacement
      if (rem_nxt != 2'd0) begin
        res.units[res.n[0]].code_unit = repl;
        res.n = res.n + 2'd1;
      end
      if (res.n == 2'd2) begin
        res.units[1].last_unit = 1'b1;
      end else if (res.n == 2'd1) begin
        res.units[0].last_unit = 1'b1;
      end
      rem_nxt      = 2'd0;
      len_nxt      = 2'd0;
      acc_nxt      = '0;
      bad_nxt      = 1'b0;
      e0_nxt       = 1'b0;
      nonascii_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= 2'd0;
      len_r      <= 2'd0;
      acc_r      <= '0;
      bad_r      <= 1'b0;
      e0_r       <= 1'b0;
      nonascii_r <= 1'b0;
    end else if (fire) begin
      rem_r      <= rem_nxt;
      len_r      <= len_nxt;
      acc_r      <= acc_nxt;
      bad_r      <= bad_nxt;
      e0_r       <= e0_nxt;
      nonascii_r <= nonascii_nxt;
    end
  end

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && eos |=> rem_r == 2'd0 && !nonascii_r && !bad_r)
    else $error("state not cleared after end of string");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    res.n == 2'd2 && !eos |-> res.units[0].code_unit[15:10] == 6'b110110
                           && res.units[1].code_unit[15:10] == 6'b110111)
    else $error("surrogate pair out of order");

  a_last_only_eos: assert property (@(posedge clk) disable iff (!rst_n)
    !eos |-> !res.units[0].last_unit && !res.units[1].last_unit)
    else $error("last unit flagged without end of string");

endmodule

// ----- src/u8u16_outq.sv -----
module u8u16_outq
  import u8u16_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  dec_res_t res,
  output logic   push_ready,
  u8u16_unit_if.source out_ch
);

  unit_t           q_r [QDEPTH];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  count_r, count_nxt;
  logic [1:0]      push_n;
  logic            pop;

  assign push_n     = push ? res.n : 2'd0;
  assign pop        = out_ch.valid && out_ch.ready;
  assign push_ready = (count_r <= QCW'(QDEPTH - 2));

  assign out_ch.valid     = (count_r != '0);
  assign out_ch.code_unit = q_r[rd_ptr_r].code_unit;
  assign out_ch.last_unit = q_r[rd_ptr_r].last_unit;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(push_n);
    rd_ptr_nxt = rd_ptr_r + QAW'(pop);
    count_nxt  = count_r + QCW'(push_n) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= res.units[0];
    end
    if (push_n == 2'd2) begin
      q_r[QAW'(wr_ptr_r + 1'b1)] <= res.units[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("output queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 && !pop |=> count_r == $past(count_r) + QCW'($past(push_n)))
    else $error("queue count lost a unit");

endmodule

// ----- src/utf8_to_utf16_decoder.sv -----
// utf-8 to utf-16 decoder: takes one utf-8 byte per word on in_ch, marked with
// end_of_string on the last byte of a string, and gives utf-16 code units on out_ch,
// last_unit marking the final unit of each string. one byte is accepted every cycle
// while in_ch.ready is high; a byte decodes in one pass of combinational logic into
// a four-entry output queue, which registers its units before out_ch shows them.
// a byte gives zero, one or two units (two only for a surrogate pair; a sequence cut
// short at string end gives a single replacement unit); in_ch.ready holds low while
// the queue holds more than two units, so the sustained rate is one byte per cycle
// as long as out_ch drains one unit per cycle.
// malformed input (bad lead, bad continuation, overlong form, surrogate value, code
// point above 10ffff, nul after a non-ascii byte, sequence cut short) gives one unit
// from the replacement register, which resets to 003f. the user must write it via
// cfg_we only while the block is idle; the block itself does not enforce this.
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  u8u16_byte_if.sink    in_ch,
  u8u16_unit_if.source  out_ch
);

  logic [15:0] repl_r;
  logic        q_ready;
  logic        fire;
  dec_res_t    res;

  // replacement code unit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else if (cfg_we) begin
      repl_r <= cfg_wdata;
    end
  end

  // queue always has room for a surrogate pair when ready is high
  assign in_ch.ready = q_ready;
  assign fire        = in_ch.valid && in_ch.ready;

  // sequence tracking and unit generation
  u8u16_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_ch.in_byte),
    .eos     (in_ch.end_of_string),
    .repl    (repl_r),
    .res     (res)
  );

  // result buffer, one unit per word out
  u8u16_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .res        (res),
    .push_ready (q_ready),
    .out_ch     (out_ch)
  );

endmodule
